// ===== src/generational_handle_allocator_core_defines.svh =====
// Assertion macros shared by the allocator RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_CORE_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define GHA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication.
`define GHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

// ===== src/gha_pkg.sv =====
// ----------------------------------------------------------------------------
// gha_pkg
// Sizes, command codes and status codes of the generational handle allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package gha_pkg;

  localparam int CAPACITY = 64;
  localparam int GEN_W    = 8;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

endpackage

`default_nettype wire

// ===== src/generational_handle_allocator_core.sv =====
// A request beat is registered into the work stage when accepted, and its result into the
// result register when the work stage fires.
// Throughput: one request beat per cycle while the result side is not stalled; the generation
// table is read once per request at acceptance and written for a fresh allocation or a valid free.
// Reset (synchronous, rst_n low) empties the free stack and the high-water mark
// and drops any beat in flight; the tables are not cleared and need no sweep.
// ----------------------------------------------------------------------------
// generational_handle_allocator_core
// Slot allocator handing out index/generation handles, with a LIFO free stack.
// ----------------------------------------------------------------------------
`default_nettype none

`include "generational_handle_allocator_core_defines.svh"

module generational_handle_allocator_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  gha_pkg::cmd_t               in_command,
  input  logic [gha_pkg::IDX_W-1:0]   in_slot_index,
  input  logic [gha_pkg::GEN_W-1:0]   in_slot_generation,
  output logic                        out_valid,
  input  logic                        out_stall,
  output gha_pkg::status_t            out_status,
  output logic [gha_pkg::IDX_W-1:0]   out_handle_index,
  output logic [gha_pkg::GEN_W-1:0]   out_handle_generation
);
  import gha_pkg::*;

  // Generation table memory and its registered read port.
  logic [GEN_W-1:0] gen_mem [CAPACITY];
  logic [GEN_W-1:0] gen_q_r;

  // Free stack: the top entry sits in a register and the entries below it in
  // a memory. The entry just below the top is kept prefetched so a pop never
  // waits on a memory read.
  logic [IDX_W-1:0] stk_mem [CAPACITY];
  logic [IDX_W-1:0] tos_r, tos_nxt;
  logic [IDX_W-1:0] sub_r;
  logic             stk_we;
  logic [IDX_W-1:0] stk_waddr;
  logic [IDX_W-1:0] stk_raddr;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] hw_r, hw_nxt;

  // Work stage.
  logic             b_valid_r, b_valid_nxt;
  cmd_t             b_cmd_r;
  logic [IDX_W-1:0] b_idx_r;
  logic [GEN_W-1:0] b_gen_r;
  logic             fwd_hit_r;
  logic [GEN_W-1:0] fwd_data_r;

  // Result register.
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [GEN_W-1:0] out_gen_r, out_gen_nxt;

  logic             in_accept;
  logic             b_fire;
  logic [GEN_W-1:0] gen_cur;
  logic             handle_ok;
  logic             push;
  logic             pop;
  logic             gw_en;
  logic [IDX_W-1:0] gw_addr;
  logic [GEN_W-1:0] gw_data;
  logic [IDX_W-1:0] rd_addr;

  assign b_fire    = b_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = b_valid_r && !b_fire;
  assign in_accept = in_valid && !in_stall;

  // The previous request may write the table at the same edge this one reads it.
  assign gen_cur   = fwd_hit_r ? fwd_data_r : gen_q_r;
  assign handle_ok = ({1'b0, b_idx_r} < hw_r) && (gen_cur == b_gen_r);

  always_comb begin
    push           = 1'b0;
    pop            = 1'b0;
    gw_en          = 1'b0;
    gw_addr        = b_idx_r;
    gw_data        = gen_cur + GEN_W'(1);
    cnt_nxt        = cnt_r;
    hw_nxt         = hw_r;
    out_status_nxt = ST_OK;
    out_idx_nxt    = b_idx_r;
    out_gen_nxt    = b_gen_r;
    if (b_fire) begin
      unique case (b_cmd_r)
        CMD_ALLOC: begin
          if (cnt_r != '0) begin
            pop         = 1'b1;
            cnt_nxt     = cnt_r - CNT_W'(1);
            out_idx_nxt = tos_r;
            out_gen_nxt = gen_cur;
          end else if (hw_r < CNT_W'(CAPACITY)) begin
            gw_en       = 1'b1;
            gw_addr     = hw_r[IDX_W-1:0];
            gw_data     = '0;
            hw_nxt      = hw_r + CNT_W'(1);
            out_idx_nxt = hw_r[IDX_W-1:0];
            out_gen_nxt = '0;
          end else begin
            out_status_nxt = ST_FULL;
            out_idx_nxt    = '0;
            out_gen_nxt    = '0;
          end
        end
        CMD_FREE: begin
          if (handle_ok) begin
            gw_en = 1'b1;
            // A push onto a full stack is dropped; the bump still happens.
            if (cnt_r < CNT_W'(CAPACITY)) begin
              push    = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end else begin
            out_status_nxt = ST_INVALID;
          end
        end
        CMD_CHECK: begin
          if (!handle_ok) begin
            out_status_nxt = ST_INVALID;
          end
        end
        CMD_CLEAR: begin
          cnt_nxt = '0;
          hw_nxt  = '0;
        end
      endcase
    end
  end

  always_comb begin
    tos_nxt = tos_r;
    if (push) begin
      tos_nxt = b_idx_r;
    end else if (pop) begin
      tos_nxt = sub_r;
    end
  end

  // A push moves the old top into the memory, one place below the new top.
  assign stk_we    = push && (cnt_r != '0);
  assign stk_waddr = IDX_W'(cnt_r - CNT_W'(1));
  assign stk_raddr = IDX_W'(cnt_nxt - CNT_W'(2));

  // An allocation reads the generation of the slot that will be on top of the stack.
  assign rd_addr = (in_command == CMD_ALLOC) ? tos_nxt : in_slot_index;

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (in_accept) begin
      b_valid_nxt = 1'b1;
    end else if (b_fire) begin
      b_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (b_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gw_en) begin
      gen_mem[gw_addr] <= gw_data;
    end
    if (in_accept) begin
      gen_q_r <= gen_mem[rd_addr];
    end
  end

  // The entry below the new top is the old top after a push, else a memory read.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= tos_r;
    end
    if (push) begin
      sub_r <= tos_r;
    end else begin
      sub_r <= stk_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
    if (in_accept) begin
      b_cmd_r    <= in_command;
      b_idx_r    <= in_slot_index;
      b_gen_r    <= in_slot_generation;
      fwd_hit_r  <= gw_en && (gw_addr == rd_addr);
      fwd_data_r <= gw_data;
    end
    if (b_fire) begin
      out_status_r <= out_status_nxt;
      out_idx_r    <= out_idx_nxt;
      out_gen_r    <= out_gen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      hw_r        <= '0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      hw_r        <= hw_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_handle_index      = out_idx_r;
  assign out_handle_generation = out_gen_r;

  `GHA_ASSERT_NOW(a_cnt_bound, 1'b1, (cnt_r <= CNT_W'(CAPACITY)) && (cnt_r <= hw_r || cnt_r != '0))
  `GHA_ASSERT_NOW(a_hw_bound, 1'b1, hw_r <= CNT_W'(CAPACITY))
  `GHA_ASSERT_NEXT(a_clear_empties, b_fire && (b_cmd_r == CMD_CLEAR), (cnt_r == '0) && (hw_r == '0))
  `GHA_ASSERT_NEXT(a_full_reported, b_fire && (b_cmd_r == CMD_ALLOC) && (cnt_r == '0) && (hw_r == CNT_W'(CAPACITY)), out_valid_r && (out_status_r == ST_FULL))

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the generational handle allocator. A request sender and a
// result checker run on valid/stall beats. The checker compares every result
// beat against a handle predictor kept inside the bench. A fixed directed
// sequence runs first. It is followed by stress sequences for capacity and
// generation wrap, and by randomized request streams under varying idle and
// stall pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import gha_pkg::*;

  typedef struct packed {
    status_t              status;
    logic [IDX_W-1:0]     index;
    logic [GEN_W-1:0]     generation;
  } handle_rsp_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  cmd_t                 in_command = CMD_ALLOC;
  logic [IDX_W-1:0]     in_slot_index = '0;
  logic [GEN_W-1:0]     in_slot_generation = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  status_t              out_status;
  logic [IDX_W-1:0]     out_handle_index;
  logic [GEN_W-1:0]     out_handle_generation;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;

  // Predicted allocator state.
  logic [IDX_W-1:0] freed_slots [CAPACITY];
  logic [GEN_W-1:0] slot_gen [CAPACITY];
  int               freed_depth = 0;
  int               slots_issued = 0;

  handle_rsp_t pending_handles [$];

  generational_handle_allocator_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_command            (in_command),
    .in_slot_index         (in_slot_index),
    .in_slot_generation    (in_slot_generation),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_handle_index      (out_handle_index),
    .out_handle_generation (out_handle_generation)
  );

  always #6 clk = ~clk;

  function automatic bit handle_live(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
    return (int'(idx) < slots_issued) && (slot_gen[idx] == gen);
  endfunction

  // Applies one request to the predicted state and returns the expected beat.
  function automatic handle_rsp_t serve_request(cmd_t cmd, logic [IDX_W-1:0] idx,
                                                logic [GEN_W-1:0] gen);
    handle_rsp_t r;
    r.status     = ST_OK;
    r.index      = idx;
    r.generation = gen;
    case (cmd)
      CMD_ALLOC: begin
        if (freed_depth > 0) begin
          freed_depth--;
          r.index      = freed_slots[freed_depth];
          r.generation = slot_gen[r.index];
        end else if (slots_issued < CAPACITY) begin
          r.index          = slots_issued[IDX_W-1:0];
          r.generation     = '0;
          slot_gen[r.index] = '0;
          slots_issued++;
        end else begin
          r.status     = ST_FULL;
          r.index      = '0;
          r.generation = '0;
        end
      end
      CMD_FREE: begin
        if (handle_live(idx, gen)) begin
          slot_gen[idx] = slot_gen[idx] + 1'b1;
          // A full stack drops the push, but the generation still moves on.
          if (freed_depth < CAPACITY) begin
            freed_slots[freed_depth] = idx;
            freed_depth++;
          end
        end else begin
          r.status = ST_INVALID;
        end
      end
      CMD_CHECK: begin
        if (!handle_live(idx, gen)) r.status = ST_INVALID;
      end
      default: begin
        freed_depth  = 0;
        slots_issued = 0;
      end
    endcase
    return r;
  endfunction

  // Called right after a rising edge; returns at the edge that accepts the beat.
  task automatic send_req(input cmd_t cmd, input logic [IDX_W-1:0] idx,
                          input logic [GEN_W-1:0] gen);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_command         <= cmd;
    in_slot_index      <= idx;
    in_slot_generation <= gen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_handles.push_back(serve_request(cmd, idx, gen));
  endtask

  task automatic send_alloc();
    send_req(CMD_ALLOC, IDX_W'($urandom_range(CAPACITY - 1)), GEN_W'($urandom_range(255)));
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_handles.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_req(CMD_ALLOC, '0, '0);
    send_req(CMD_ALLOC, '1, '1);
    send_req(CMD_CHECK, 6'd0, 8'd0);
    send_req(CMD_CHECK, 6'd1, 8'd255);
    send_req(CMD_CHECK, 6'd63, 8'd0);
    send_req(CMD_CHECK, 6'd2, 8'd0);
    send_req(CMD_FREE, 6'd1, 8'd0);
    send_req(CMD_FREE, 6'd1, 8'd0);
    // Repeat free that presents the already bumped generation is accepted.
    send_req(CMD_FREE, 6'd1, 8'd1);
    send_req(CMD_ALLOC, 6'd0, 8'd0);
    send_req(CMD_ALLOC, 6'd0, 8'd0);
    send_req(CMD_ALLOC, 6'd0, 8'd0);
    send_req(CMD_FREE, 6'd0, 8'd0);
    send_req(CMD_CHECK, 6'd0, 8'd1);
    send_req(CMD_FREE, 6'd63, 8'd255);
    send_req(CMD_CLEAR, 6'd63, 8'd255);
    send_req(CMD_CHECK, 6'd0, 8'd1);
    send_req(CMD_ALLOC, '1, '1);
    send_req(CMD_FREE, 6'd0, 8'd0);
    send_req(CMD_ALLOC, 6'd0, 8'd0);
    send_req(CMD_CLEAR, 6'd0, 8'd0);
  endtask

  task automatic test_random(input int n_items);
    cmd_t             cmd;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
    int               pick;
    repeat (n_items) begin
      pick = $urandom_range(99);
      idx  = IDX_W'($urandom_range(CAPACITY - 1));
      gen  = GEN_W'($urandom_range(255));
      if (pick < 38) cmd = CMD_ALLOC;
      else if (pick < 68) cmd = CMD_FREE;
      else if (pick < 96) cmd = CMD_CHECK;
      else cmd = CMD_CLEAR;
      if ((cmd == CMD_FREE || cmd == CMD_CHECK) && slots_issued > 0) begin
        pick = $urandom_range(99);
        if (pick < 85) idx = IDX_W'($urandom_range(slots_issued - 1));
        if (pick < 70) gen = slot_gen[idx];
        else if (pick < 85) gen = slot_gen[idx] + GEN_W'($urandom_range(1, 255));
      end
      send_req(cmd, idx, gen);
    end
  endtask

  task automatic test_capacity();
    logic [IDX_W-1:0] idx;
    send_req(CMD_CLEAR, IDX_W'($urandom_range(CAPACITY - 1)), GEN_W'($urandom_range(255)));
    repeat (CAPACITY + 3) send_alloc();
    repeat (24) begin
      idx = IDX_W'($urandom_range(CAPACITY - 1));
      send_req(CMD_FREE, idx, slot_gen[idx]);
      if ($urandom_range(3) == 0) send_req(CMD_CHECK, idx, slot_gen[idx]);
    end
    repeat (30) send_alloc();
  endtask

  // Frees one slot over and over: the generation wraps and the stack overflows.
  task automatic test_generation_wrap();
    send_req(CMD_CLEAR, '0, '0);
    send_alloc();
    repeat (260) send_req(CMD_FREE, 6'd0, slot_gen[0]);
    send_req(CMD_CHECK, 6'd0, slot_gen[0]);
    repeat (CAPACITY + 2) send_alloc();
  endtask

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    handle_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_handles.size() == 0) begin
        $error("unexpected result beat: status %0d index %0d generation %0d",
               out_status, out_handle_index, out_handle_generation);
        fail_count++;
      end else begin
        want = pending_handles.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_handle_index !== want.index) begin
          $error("handle_index: expected %0d, got %0d", want.index, out_handle_index);
          fail_count++;
        end
        if (out_handle_generation !== want.generation) begin
          $error("handle_generation: expected %0d, got %0d",
                 want.generation, out_handle_generation);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 21;
    recv_stall_pct = 73;
    test_directed();
    test_random(300);

    send_idle_pct  = 73;
    recv_stall_pct = 21;
    test_capacity();
    test_random(300);
    pause_until_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_generation_wrap();
    test_random(350);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_handles.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/gha_pkg.sv
src/generational_handle_allocator_core.sv
dv/tb_top.sv
